// ----- hw/rtl/tdm_pkg.sv -----
// Shared types, codes and constants of the teleop drive mixer.
// Used by every module of the block; depends on nothing.
package tdm_pkg;

  // Field widths
  localparam int unsigned PulseW   = 11;
  localparam int unsigned StepW    = 9;
  localparam int unsigned TimeW    = 15;
  localparam int unsigned AgeW     = 16;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned OpW      = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CruiseW  = 2;

  // Drive limits
  localparam logic [StepW-1:0]  SpeedMax = 9'd450;
  localparam logic [StepW-1:0]  SpeedMin = 9'd25;
  localparam logic [StepW-1:0]  SpeedInc = 9'd25;
  localparam logic [PulseW-1:0] PwmMin   = 11'd1000;
  localparam logic [PulseW-1:0] PwmMax   = 11'd2000;
  localparam logic [AgeW-1:0]   AgeMax   = 16'hFFFF;

  // Register reset values
  localparam logic [PulseW-1:0] NeutralRst   = 11'd1500;
  localparam logic [StepW-1:0]  InitStepRst  = 9'd50;
  localparam logic [PulseW-1:0] SteerLeftRst = 11'd1350;
  localparam logic [PulseW-1:0] SteerRightRst = 11'd1650;
  localparam logic [TimeW-1:0]  RemoteTmoRst = 15'd800;
  localparam logic [TimeW-1:0]  LocalTmoRst  = 15'd200;

  // Register indexes
  localparam logic [CfgAddrW-1:0] CfgNeutral    = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgInitStep   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgSteerLeft  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgSteerRight = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgRemoteTmo  = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgLocalTmo   = 3'd5;

  // Cruise mode codes
  localparam logic [CruiseW-1:0] CruiseOff = 2'd0;
  localparam logic [CruiseW-1:0] CruiseFwd = 2'd1;
  localparam logic [CruiseW-1:0] CruiseRev = 2'd2;

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 4'd0,
    OP_FWD         = 4'd1,
    OP_REV         = 4'd2,
    OP_LEFT        = 4'd3,
    OP_RIGHT       = 4'd4,
    OP_CRUISE_FWD  = 4'd5,
    OP_CRUISE_REV  = 4'd6,
    OP_FASTER      = 4'd7,
    OP_SLOWER      = 4'd8,
    OP_STOP        = 4'd9,
    OP_LINK_STATUS = 4'd10
  } op_e;

  typedef struct packed {
    logic [PulseW-1:0] neutral;
    logic [StepW-1:0]  init_step;
    logic [PulseW-1:0] steer_left;
    logic [PulseW-1:0] steer_right;
    logic [TimeW-1:0]  remote_tmo;
    logic [TimeW-1:0]  local_tmo;
  } cfg_t;

  typedef struct packed {
    op_e  operation;
    logic from_remote;
    logic link_connected;
    logic link_armed;
  } item_t;

  typedef struct packed {
    logic [PulseW-1:0]  motor_one;
    logic [PulseW-1:0]  motor_two;
    logic               remote_active;
    logic [CruiseW-1:0] cruise_mode;
  } result_t;

endpackage

// ----- hw/rtl/tdm_cfg_regs.sv -----
// Configuration register file of the teleop drive mixer.
// Depends on tdm_pkg for the register indexes, reset values and cfg_t.
module tdm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [tdm_pkg::CfgAddrW-1:0]  wr_addr_i,
  input  logic [tdm_pkg::CfgDataW-1:0]  wr_data_i,
  output tdm_pkg::cfg_t                 cfg_o
);

  tdm_pkg::cfg_t cfg_q;

  // Write one register per transfer; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral     <= tdm_pkg::NeutralRst;
      cfg_q.init_step   <= tdm_pkg::InitStepRst;
      cfg_q.steer_left  <= tdm_pkg::SteerLeftRst;
      cfg_q.steer_right <= tdm_pkg::SteerRightRst;
      cfg_q.remote_tmo  <= tdm_pkg::RemoteTmoRst;
      cfg_q.local_tmo   <= tdm_pkg::LocalTmoRst;
    end else if (wr_en_i) begin
      case (wr_addr_i)
        tdm_pkg::CfgNeutral:    cfg_q.neutral     <= wr_data_i[tdm_pkg::PulseW-1:0];
        tdm_pkg::CfgInitStep:   cfg_q.init_step   <= wr_data_i[tdm_pkg::StepW-1:0];
        tdm_pkg::CfgSteerLeft:  cfg_q.steer_left  <= wr_data_i[tdm_pkg::PulseW-1:0];
        tdm_pkg::CfgSteerRight: cfg_q.steer_right <= wr_data_i[tdm_pkg::PulseW-1:0];
        tdm_pkg::CfgRemoteTmo:  cfg_q.remote_tmo  <= wr_data_i[tdm_pkg::TimeW-1:0];
        tdm_pkg::CfgLocalTmo:   cfg_q.local_tmo   <= wr_data_i[tdm_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/tdm_state.sv -----
// Drive state registers and the per-item update and mixing logic.
// Depends on tdm_pkg for op_e, item_t, cfg_t, result_t and drive limits.
module tdm_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  tdm_pkg::item_t   item_i,
  input  tdm_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output tdm_pkg::result_t res_o
);

  localparam int unsigned PW = tdm_pkg::PulseW;
  localparam int unsigned SW = tdm_pkg::StepW;
  localparam int unsigned AW = tdm_pkg::AgeW;
  localparam int unsigned TW = tdm_pkg::ThrW;

  logic [TW-1:0] throttle_q, throttle_d;
  logic [PW-1:0] steering_q, steering_d;
  logic [SW-1:0] speed_q, speed_d;
  logic          cruise_fwd_q, cruise_fwd_d;
  logic          cruise_rev_q, cruise_rev_d;
  logic          remote_mode_q, remote_mode_d;
  logic          link_up_q, link_up_d;
  logic          armed_q, armed_d;
  logic [AW-1:0] thr_age_q, thr_age_d;
  logic [AW-1:0] steer_age_q, steer_age_d;
  logic [AW-1:0] rem_age_q, rem_age_d;

  // Tick path signals
  logic [AW-1:0]    thr_age_inc, steer_age_inc, rem_age_inc;
  logic [AW-2:0]    timeout;
  logic [PW-1:0]    steer_tick;
  logic [TW-1:0]    thr_tick;
  logic             rm_tick;
  logic [TW:0]      lin;
  logic [TW-1:0]    off;
  logic [TW+1:0]    sum_one, sum_two;
  logic [PW-1:0]    mix_one, mix_two;

  // Command path signals
  logic [TW-1:0]    thr_fwd, thr_rev;
  logic [SW:0]      speed_up;
  logic             cmd_accept;

  function automatic logic [AW-1:0] age_inc(input logic [AW-1:0] a);
    age_inc = (a == tdm_pkg::AgeMax) ? a : a + AW'(1);
  endfunction

  function automatic logic [PW-1:0] clamp_pwm(input logic [TW+1:0] v);
    logic signed [TW+1:0] s;
    s = $signed(v);
    if (s < $signed({3'b000, tdm_pkg::PwmMin})) begin
      clamp_pwm = tdm_pkg::PwmMin;
    end else if (s > $signed({3'b000, tdm_pkg::PwmMax})) begin
      clamp_pwm = tdm_pkg::PwmMax;
    end else begin
      clamp_pwm = v[PW-1:0];
    end
  endfunction

  // Timeouts, remote expiry and differential mix for a tick
  always_comb begin
    thr_age_inc   = age_inc(thr_age_q);
    steer_age_inc = age_inc(steer_age_q);
    rem_age_inc   = age_inc(rem_age_q);
    timeout       = remote_mode_q ? cfg_i.remote_tmo : cfg_i.local_tmo;
    steer_tick    = (steer_age_inc > {1'b0, timeout}) ? cfg_i.neutral : steering_q;
    thr_tick      = (!cruise_fwd_q && !cruise_rev_q && (thr_age_inc > {1'b0, timeout}))
                    ? {1'b0, cfg_i.neutral} : throttle_q;
    rm_tick       = remote_mode_q && !(rem_age_inc > {cfg_i.remote_tmo, 1'b0});
    if (cruise_fwd_q) begin
      lin = {2'b00, cfg_i.neutral} + {4'b0000, speed_q};
    end else if (cruise_rev_q) begin
      lin = {2'b00, cfg_i.neutral} - {4'b0000, speed_q};
    end else begin
      lin = {1'b0, thr_tick};
    end
    off     = {1'b0, steer_tick} - {1'b0, cfg_i.neutral};
    sum_one = {lin[TW], lin} + {{2{off[TW-1]}}, off};
    sum_two = {lin[TW], lin} - {{2{off[TW-1]}}, off};
    mix_one = clamp_pwm(sum_one);
    mix_two = clamp_pwm(sum_two);
  end

  // Result of a tick with the link up
  always_comb begin
    res_valid_o = (item_i.operation == tdm_pkg::OP_TICK) && link_up_q;
    if (armed_q) begin
      res_o.motor_one     = mix_one;
      res_o.motor_two     = mix_two;
      res_o.remote_active = rm_tick;
      res_o.cruise_mode   = cruise_fwd_q ? tdm_pkg::CruiseFwd :
                            (cruise_rev_q ? tdm_pkg::CruiseRev : tdm_pkg::CruiseOff);
    end else begin
      res_o.motor_one     = cfg_i.neutral;
      res_o.motor_two     = cfg_i.neutral;
      res_o.remote_active = 1'b0;
      res_o.cruise_mode   = tdm_pkg::CruiseOff;
    end
  end

  // Drive command helpers
  always_comb begin
    thr_fwd    = {1'b0, cfg_i.neutral} + {3'b000, speed_q};
    thr_rev    = ({1'b0, cfg_i.neutral} >= {3'b000, speed_q})
                 ? ({1'b0, cfg_i.neutral} - {3'b000, speed_q}) : '0;
    speed_up   = {1'b0, speed_q} + {1'b0, tdm_pkg::SpeedInc};
    cmd_accept = item_i.from_remote || !remote_mode_q;
  end

  // Next state
  always_comb begin
    throttle_d    = throttle_q;
    steering_d    = steering_q;
    speed_d       = speed_q;
    cruise_fwd_d  = cruise_fwd_q;
    cruise_rev_d  = cruise_rev_q;
    remote_mode_d = remote_mode_q;
    link_up_d     = link_up_q;
    armed_d       = armed_q;
    thr_age_d     = thr_age_q;
    steer_age_d   = steer_age_q;
    rem_age_d     = rem_age_q;
    if (step_en_i) begin
      case (item_i.operation)
        tdm_pkg::OP_TICK: begin
          thr_age_d   = thr_age_inc;
          steer_age_d = steer_age_inc;
          rem_age_d   = rem_age_inc;
          if (link_up_q) begin
            if (armed_q) begin
              throttle_d    = thr_tick;
              steering_d    = steer_tick;
              remote_mode_d = rm_tick;
            end else begin
              throttle_d    = {1'b0, cfg_i.neutral};
              steering_d    = cfg_i.neutral;
              cruise_fwd_d  = 1'b0;
              cruise_rev_d  = 1'b0;
              remote_mode_d = 1'b0;
            end
          end
        end
        tdm_pkg::OP_LINK_STATUS: begin
          link_up_d = item_i.link_connected;
          armed_d   = item_i.link_armed;
        end
        default: begin
          // Drive commands; remote ones claim remote mode first
          if (item_i.from_remote) begin
            remote_mode_d = 1'b1;
            rem_age_d     = '0;
          end
          if (cmd_accept) begin
            case (item_i.operation)
              tdm_pkg::OP_FWD: begin
                cruise_fwd_d = 1'b0;
                cruise_rev_d = 1'b0;
                throttle_d   = thr_fwd;
                thr_age_d    = '0;
              end
              tdm_pkg::OP_REV: begin
                cruise_fwd_d = 1'b0;
                cruise_rev_d = 1'b0;
                throttle_d   = thr_rev;
                thr_age_d    = '0;
              end
              tdm_pkg::OP_LEFT: begin
                steering_d  = cfg_i.steer_left;
                steer_age_d = '0;
              end
              tdm_pkg::OP_RIGHT: begin
                steering_d  = cfg_i.steer_right;
                steer_age_d = '0;
              end
              tdm_pkg::OP_CRUISE_FWD: begin
                cruise_fwd_d = !cruise_fwd_q;
                cruise_rev_d = 1'b0;
                throttle_d   = {1'b0, cfg_i.neutral};
                steering_d   = cfg_i.neutral;
              end
              tdm_pkg::OP_CRUISE_REV: begin
                cruise_rev_d = !cruise_rev_q;
                cruise_fwd_d = 1'b0;
                throttle_d   = {1'b0, cfg_i.neutral};
                steering_d   = cfg_i.neutral;
              end
              tdm_pkg::OP_FASTER: begin
                speed_d = (speed_up > {1'b0, tdm_pkg::SpeedMax})
                          ? tdm_pkg::SpeedMax : speed_up[SW-1:0];
              end
              tdm_pkg::OP_SLOWER: begin
                // Below twice the increment the step bottoms out at the minimum
                speed_d = ({1'b0, speed_q} < {tdm_pkg::SpeedInc, 1'b0})
                          ? tdm_pkg::SpeedMin : speed_q - tdm_pkg::SpeedInc;
              end
              tdm_pkg::OP_STOP: begin
                cruise_fwd_d  = 1'b0;
                cruise_rev_d  = 1'b0;
                throttle_d    = {1'b0, cfg_i.neutral};
                steering_d    = cfg_i.neutral;
                remote_mode_d = 1'b0;
              end
              default: begin
                // Unused codes leave everything as is
                remote_mode_d = remote_mode_q;
                rem_age_d     = rem_age_q;
              end
            endcase
          end else if (item_i.operation > tdm_pkg::OP_LINK_STATUS) begin
            remote_mode_d = remote_mode_q;
            rem_age_d     = rem_age_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q    <= {1'b0, tdm_pkg::NeutralRst};
      steering_q    <= tdm_pkg::NeutralRst;
      speed_q       <= tdm_pkg::InitStepRst;
      cruise_fwd_q  <= 1'b0;
      cruise_rev_q  <= 1'b0;
      remote_mode_q <= 1'b0;
      link_up_q     <= 1'b0;
      armed_q       <= 1'b0;
      thr_age_q     <= '0;
      steer_age_q   <= '0;
      rem_age_q     <= '0;
    end else begin
      throttle_q    <= throttle_d;
      steering_q    <= steering_d;
      speed_q       <= speed_d;
      cruise_fwd_q  <= cruise_fwd_d;
      cruise_rev_q  <= cruise_rev_d;
      remote_mode_q <= remote_mode_d;
      link_up_q     <= link_up_d;
      armed_q       <= armed_d;
      thr_age_q     <= thr_age_d;
      steer_age_q   <= steer_age_d;
      rem_age_q     <= rem_age_d;
    end
  end

endmodule

// ----- hw/rtl/teleop_drive_mixer_unit.sv -----
// A tick is held in the input register; when it advances, its result is
// loaded into the output register and driven on the output from there.
// Throughput: one item per cycle; the input register stalls only while a
// finished result waits in the output register and the held item is a tick
// with the link up. Other items never stall and give no result.
// Reset (rst_ni low, asynchronous) clears both stages, the drive state and
// the configuration registers to their documented defaults.
module teleop_drive_mixer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [0] from_remote, [1] link_connected,
                                                      // [2] link_armed, [7:3] zero
  input  logic [3:0]                   s_axis_tuser,  // [3:0] operation
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // [10:0] motor_one_pulse,
                                                      // [21:11] motor_two_pulse,
                                                      // [22] remote_active,
                                                      // [24:23] cruise_mode, [31:25] zero
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tdm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tdm_pkg::CfgDataW-1:0] cfg_data_i
);

  tdm_pkg::cfg_t    cfg;
  tdm_pkg::item_t   item_q;
  tdm_pkg::result_t res, res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             res_valid;
  logic             advance;

  assign cfg_ready_o = 1'b1;

  tdm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Advance the held item unless its result would overwrite a waiting one
  assign advance       = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.operation      <= tdm_pkg::op_e'(s_axis_tuser);
      item_q.from_remote    <= s_axis_tdata[0];
      item_q.link_connected <= s_axis_tdata[1];
      item_q.link_armed     <= s_axis_tdata[2];
    end
  end

  tdm_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (advance),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new result, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, res_q.cruise_mode, res_q.remote_active,
                          res_q.motor_two, res_q.motor_one};

endmodule

// ----- hw/rtl/tdm_checker.sv -----
// Port-level checks of the teleop drive mixer, bound to the top level.
// Depends on tdm_pkg for the operation and cruise codes.
module tdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [3:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  logic tick_xfer;
  logic cfg_xfer;

  assign tick_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tdm_pkg::OP_TICK);
  assign cfg_xfer  = cfg_valid_i && cfg_ready_o;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // A fresh result comes from an earlier tick transfer
  a_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tick_xfer, 2))
    else $error("result without a tick");

  // Input stalls only under output backpressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without backpressure");

  // Cruise never reports both directions; config port always takes a write
  a_cruise_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid || cfg_valid_i) |->
      ((m_axis_tdata[24:23] <= tdm_pkg::CruiseRev || !m_axis_tvalid) &&
       (cfg_xfer || !cfg_valid_i)))
    else $error("bad cruise code or refused config write");

endmodule

bind teleop_drive_mixer_unit tdm_checker u_tdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

// ----- tb/tb.sv -----
// Self-checking bench for teleop_drive_mixer_unit: drives command, link and tick
// transfers, predicts every motor result in-bench and compares field by field.
// Depends on tdm_pkg and the teleop_drive_mixer_unit RTL only.
module tb;
  import tdm_pkg::*;

  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 4;

  // Register indexes past the last register: writes there must be ignored
  localparam logic [CfgAddrW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgAddrW-1:0] CfgSpareHi = 3'd7;
  // Operation codes past the link status code: ignored by the block
  localparam logic [OpW-1:0] OpSpareLo = 4'd11;
  localparam logic [OpW-1:0] OpSpareHi = 4'd15;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic               rem;
    logic               conn;
    logic               arm;
    logic               typed;
    logic [PulseW-1:0]  m1;
    logic [PulseW-1:0]  m2;
    logic               ra;
    logic [CruiseW-1:0] cm;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic [3:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;

  teleop_drive_mixer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted registers and drive state
  logic [PulseW-1:0] cfg_neutral, cfg_left, cfg_right;
  logic [StepW-1:0]  cfg_init_step;
  logic [TimeW-1:0]  cfg_rtmo, cfg_ltmo;
  logic [ThrW-1:0]   thr_pulse, steer_pulse;
  logic [StepW-1:0]  spd_step;
  logic              cr_fwd, cr_rev, rmode, link_ok, armed;
  logic [AgeW-1:0]   thr_age, steer_age, rem_age;

  result_t   motor_expect_q[$];
  result_t   want;
  dir_row_t  dir_rows [25];
  bit        idle_on;
  int        mismatches, results_seen, items_sent, cfg_writes;
  int        stall_cycles;

  // Clock: period 12
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void reset_drive_state();
    cfg_neutral   = NeutralRst;
    cfg_init_step = InitStepRst;
    cfg_left      = SteerLeftRst;
    cfg_right     = SteerRightRst;
    cfg_rtmo      = RemoteTmoRst;
    cfg_ltmo      = LocalTmoRst;
    thr_pulse     = {1'b0, cfg_neutral};
    steer_pulse   = {1'b0, cfg_neutral};
    spd_step      = cfg_init_step;
    cr_fwd        = 1'b0;
    cr_rev        = 1'b0;
    rmode         = 1'b0;
    link_ok       = 1'b0;
    armed         = 1'b0;
    thr_age       = '0;
    steer_age     = '0;
    rem_age       = '0;
  endfunction

  // Queue one predicted result behind the older ones
  function automatic void expect_add(input result_t r);
    motor_expect_q.insert(motor_expect_q.size(), r);
  endfunction

  function automatic void reg_apply(input logic [CfgAddrW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CfgNeutral:    cfg_neutral   = val[PulseW-1:0];
      CfgInitStep:   cfg_init_step = val[StepW-1:0];
      CfgSteerLeft:  cfg_left      = val[PulseW-1:0];
      CfgSteerRight: cfg_right     = val[PulseW-1:0];
      CfgRemoteTmo:  cfg_rtmo      = val[TimeW-1:0];
      CfgLocalTmo:   cfg_ltmo      = val[TimeW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [AgeW-1:0] age_bump(input logic [AgeW-1:0] a);
    return (a == AgeMax) ? a : a + 1'b1;
  endfunction

  function automatic logic [PulseW-1:0] pwm_limit(input int v);
    if (v < int'(PwmMin)) return PwmMin;
    if (v > int'(PwmMax)) return PwmMax;
    return v[PulseW-1:0];
  endfunction

  // Advance the drive state by one item; return 1 when a motor result follows
  function automatic bit mix_step(input logic [OpW-1:0] op, input logic rem,
                                  input logic conn, input logic arm,
                                  output result_t res);
    int v, hold, lin, off;
    res = '0;
    if (op >= OP_FWD && op <= OP_STOP) begin
      if (rem) begin
        rmode   = 1'b1;
        rem_age = '0;
      end else if (rmode) begin
        return 1'b0;
      end
      case (op)
        OP_FWD, OP_REV: begin
          cr_fwd = 1'b0;
          cr_rev = 1'b0;
          if (op == OP_FWD) v = int'(cfg_neutral) + int'(spd_step);
          else v = int'(cfg_neutral) - int'(spd_step);
          if (v < 0) v = 0;
          thr_pulse = v[ThrW-1:0];
          thr_age   = '0;
        end
        OP_LEFT: begin
          steer_pulse = {1'b0, cfg_left};
          steer_age   = '0;
        end
        OP_RIGHT: begin
          steer_pulse = {1'b0, cfg_right};
          steer_age   = '0;
        end
        OP_CRUISE_FWD: begin
          cr_fwd      = !cr_fwd;
          cr_rev      = 1'b0;
          thr_pulse   = {1'b0, cfg_neutral};
          steer_pulse = {1'b0, cfg_neutral};
        end
        OP_CRUISE_REV: begin
          cr_rev      = !cr_rev;
          cr_fwd      = 1'b0;
          thr_pulse   = {1'b0, cfg_neutral};
          steer_pulse = {1'b0, cfg_neutral};
        end
        OP_FASTER: begin
          v = int'(spd_step) + int'(SpeedInc);
          if (v > int'(SpeedMax)) spd_step = SpeedMax;
          else spd_step = v[StepW-1:0];
        end
        OP_SLOWER: begin
          v = int'(spd_step) - int'(SpeedInc);
          if (v < int'(SpeedMin)) spd_step = SpeedMin;
          else spd_step = v[StepW-1:0];
        end
        default: begin
          cr_fwd      = 1'b0;
          cr_rev      = 1'b0;
          thr_pulse   = {1'b0, cfg_neutral};
          steer_pulse = {1'b0, cfg_neutral};
          rmode       = 1'b0;
        end
      endcase
      return 1'b0;
    end
    if (op == OP_LINK_STATUS) begin
      link_ok = conn;
      armed   = arm;
      return 1'b0;
    end
    if (op != OP_TICK) return 1'b0;

    // Ages run even with the link down
    thr_age   = age_bump(thr_age);
    steer_age = age_bump(steer_age);
    rem_age   = age_bump(rem_age);
    if (!link_ok) return 1'b0;

    // Hold time follows remote mode as it stood before its own expiry
    hold = rmode ? int'(cfg_rtmo) : int'(cfg_ltmo);
    if (int'(steer_age) > hold) steer_pulse = {1'b0, cfg_neutral};
    if (!cr_fwd && !cr_rev && int'(thr_age) > hold) thr_pulse = {1'b0, cfg_neutral};
    if (rmode && int'(rem_age) > 2 * int'(cfg_rtmo)) rmode = 1'b0;

    if (armed) begin
      if (cr_fwd) lin = int'(cfg_neutral) + int'(spd_step);
      else if (cr_rev) lin = int'(cfg_neutral) - int'(spd_step);
      else lin = int'(thr_pulse);
      off = int'(steer_pulse) - int'(cfg_neutral);
      res.motor_one = pwm_limit(lin + off);
      res.motor_two = pwm_limit(lin - off);
    end else begin
      // Disarmed: neutral out, everything back to rest
      res.motor_one = cfg_neutral;
      res.motor_two = cfg_neutral;
      thr_pulse     = {1'b0, cfg_neutral};
      steer_pulse   = {1'b0, cfg_neutral};
      cr_fwd        = 1'b0;
      cr_rev        = 1'b0;
      rmode         = 1'b0;
    end
    res.remote_active = rmode;
    res.cruise_mode   = cr_fwd ? CruiseFwd : (cr_rev ? CruiseRev : CruiseOff);
    return 1'b1;
  endfunction

  // Offer one item, hold it until the transfer, then record its outcome
  task automatic send_item(input logic [OpW-1:0] op, input logic rem,
                           input logic conn, input logic arm,
                           input bit typed = 1'b0, input result_t typed_res = '0);
    result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, arm, conn, rem};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (mix_step(op, rem, conn, arm, res)) begin
      expect_add(typed ? typed_res : res);
    end
    @(negedge clk_i);
  endtask

  // Drop valid and wait until the pipeline has nothing left in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (motor_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_apply(idx, val);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [CfgDataW-1:0] neutral,
                              input logic [CfgDataW-1:0] init_step,
                              input logic [CfgDataW-1:0] left,
                              input logic [CfgDataW-1:0] right,
                              input logic [CfgDataW-1:0] rtmo,
                              input logic [CfgDataW-1:0] ltmo);
    settle();
    write_reg(CfgNeutral, neutral);
    write_reg(CfgInitStep, init_step);
    write_reg(CfgSteerLeft, left);
    write_reg(CfgSteerRight, right);
    write_reg(CfgRemoteTmo, rtmo);
    write_reg(CfgLocalTmo, ltmo);
    write_reg(CfgSpareLo, CfgDataW'($urandom));
    write_reg(CfgSpareHi, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly tick runs and drive commands on a live link; some link drops,
  // disarms and unused codes mixed in
  task automatic run_random(input int n, input bit quiet);
    int sent, pick, burst;
    sent    = 0;
    idle_on = !quiet;
    while (sent < n) begin
      if (!quiet && $urandom_range(0, 40) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        repeat (burst) begin
          send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
        sent += burst;
      end else if (pick < 88) begin
        send_item(OpW'($urandom_range(int'(OP_FWD), int'(OP_STOP))),
                  $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 96) begin
        send_item(OP_LINK_STATUS, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                  $urandom_range(0, 5) != 0);
        sent++;
      end else begin
        send_item(OpW'($urandom_range(int'(OpSpareLo), int'(OpSpareHi))),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // Result side: stall in short bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (motor_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %0d: tdata=%h", results_seen, m_axis_tdata);
        end
      end else begin
        want = motor_expect_q.pop_front();
        if (m_axis_tdata[10:0] !== want.motor_one || m_axis_tdata[21:11] !== want.motor_two ||
            m_axis_tdata[22] !== want.remote_active ||
            m_axis_tdata[24:23] !== want.cruise_mode) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected m1=%0d m2=%0d remote=%0b cruise=%0d",
                     results_seen, want.motor_one, want.motor_two, want.remote_active,
                     want.cruise_mode);
            $display("           got      m1=%0d m2=%0d remote=%0b cruise=%0d",
                     m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tdata[22],
                     m_axis_tdata[24:23]);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               stall_cycles, motor_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stim
    dir_row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CfgNeutral;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    items_sent    = 0;
    cfg_writes    = 0;
    reset_drive_state();

    // Directed rows: op, remote, link up, armed, typed, motor one/two, remote, cruise
    dir_rows = '{
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_LINK_STATUS, 1'b0, 1'b1, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 11'd1500, 11'd1500, 1'b0, CruiseOff},
      '{OP_FWD,         1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 11'd1550, 11'd1550, 1'b0, CruiseOff},
      '{OP_LEFT,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 11'd1400, 11'd1700, 1'b0, CruiseOff},
      '{OP_RIGHT,       1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 11'd1700, 11'd1400, 1'b1, CruiseOff},
      '{OP_FWD,         1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_STOP,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_FASTER,      1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_CRUISE_FWD,  1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_CRUISE_REV,  1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_SLOWER,      1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_STOP,        1'b1, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_REV,         1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OpSpareHi,      1'b1, 1'b1, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_LINK_STATUS, 1'b0, 1'b1, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff},
      '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 11'd1500, 11'd1500, 1'b0, CruiseOff},
      '{OP_LINK_STATUS, 1'b0, 1'b1, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0, CruiseOff}
    };

    // Hold reset, then release it on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.op, row.rem, row.conn, row.arm, row.typed,
                '{row.m1, row.m2, row.ra, row.cm});
    end

    // Low extremes: zero hold times, full-swing steering
    load_setting(15'd1000, 15'd25, 15'd1000, 15'd2000, 15'd0, 15'd0);
    run_random(150, 1'b0);
    // High extremes: hold times of 30000
    load_setting(15'd2000, 15'd450, 15'd2000, 15'd1000, 15'd30000, 15'd30000);
    run_random(150, 1'b0);
    // Out-of-range values: upper data bits dropped, neutral at zero
    load_setting(15'h7800, 15'h7FFF, 15'h7FFF, 15'h0000, 15'd3, 15'd1);
    run_random(150, 1'b0);
    repeat (2) begin
      load_setting(15'($urandom_range(1000, 2000)), 15'($urandom_range(25, 450)),
                   15'($urandom_range(1000, 2000)), 15'($urandom_range(1000, 2000)),
                   15'($urandom_range(0, 25)), 15'($urandom_range(0, 25)));
      run_random(165, 1'b0);
    end
    // Closing stretch at full rate on both sides
    load_setting(15'($urandom_range(1000, 2000)), 15'($urandom_range(25, 450)),
                 15'($urandom_range(1000, 2000)), 15'($urandom_range(1000, 2000)),
                 15'($urandom_range(0, 25)), 15'($urandom_range(0, 25)));
    run_random(165, 1'b1);
    settle();

    $display("Drove %0d command, link and tick items over six register settings (%0d writes).",
             items_sent, cfg_writes);
    $display("Checked %0d motor results: %0d mismatches, %0d still pending.",
             results_seen, mismatches, motor_expect_q.size());
    if (mismatches == 0 && motor_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tdm_pkg.sv
hw/rtl/tdm_cfg_regs.sv
hw/rtl/tdm_state.sv
hw/rtl/teleop_drive_mixer_unit.sv
hw/rtl/tdm_checker.sv
tb/tb.sv
